### design/hslrgb_pkg.sv
// Shared constants for the HSL to RGB converter.
// No dependencies; imported by every module of the block.
package hslrgb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SECTOR_W      = 3;

    // Hue sectors, one per sixth of a turn; a hue of exactly one is in none
    localparam logic [SECTOR_W-1:0] SEC_RED_YEL  = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_YEL_GRN  = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_GRN_CYN  = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYN_BLU  = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLU_MAG  = 3'd4;
    localparam logic [SECTOR_W-1:0] SEC_MAG_RED  = 3'd5;

endpackage

### design/hslrgb_front.sv
// First pipeline stage: input clamping, lightness span, hue sector split and x weight.
// Depends on hslrgb_pkg.
module hslrgb_front #(
    parameter int FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [FRAC_BITS:0]                hue,
    input  logic [FRAC_BITS:0]                saturation,
    input  logic [FRAC_BITS:0]                lightness,
    output logic                              s1_valid,
    output logic [FRAC_BITS:0]                s1_span,
    output logic [FRAC_BITS:0]                s1_sat,
    output logic [FRAC_BITS:0]                s1_light,
    output logic [FRAC_BITS:0]                s1_hx,
    output logic [hslrgb_pkg::SECTOR_W-1:0]   s1_sector
);
    import hslrgb_pkg::*;

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [W-1:0]        h_c, s_c, l_c;
    logic [W:0]          l2, l2_dist;
    logic [W-1:0]        span_next;
    logic [W+1:0]        hp;
    logic [W-1:0]        wrapped, w_dist, hx_next;

    logic                valid_reg;
    logic [W-1:0]        span_reg, sat_reg, light_reg, hx_reg;
    logic [SECTOR_W-1:0] sector_reg;

    always_comb
    begin
        h_c = (hue > ONE) ? ONE : hue;
        s_c = (saturation > ONE) ? ONE : saturation;
        l_c = (lightness > ONE) ? ONE : lightness;

        l2        = {l_c, 1'b0};
        l2_dist   = (l2 > {1'b0, ONE}) ? (l2 - {1'b0, ONE}) : ({1'b0, ONE} - l2);
        span_next = ONE - l2_dist[W-1:0];

        // 6h = 4h + 2h
        hp      = {h_c, 2'b00} + {1'b0, h_c, 1'b0};
        wrapped = hp[W-1:0];
        w_dist  = (wrapped > ONE) ? (wrapped - ONE) : (ONE - wrapped);
        hx_next = ONE - w_dist;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg   <= span_next;
        sat_reg    <= s_c;
        light_reg  <= l_c;
        hx_reg     <= hx_next;
        sector_reg <= hp[W+1:FRAC_BITS];
    end

    assign s1_valid  = valid_reg;
    assign s1_span   = span_reg;
    assign s1_sat    = sat_reg;
    assign s1_light  = light_reg;
    assign s1_hx     = hx_reg;
    assign s1_sector = sector_reg;

endmodule

### design/hslrgb_mul.sv
// Second and third pipeline stages: chroma product, then x product and offset.
// Depends on hslrgb_pkg.
module hslrgb_mul #(
    parameter int FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s1_valid,
    input  logic [FRAC_BITS:0]                s1_span,
    input  logic [FRAC_BITS:0]                s1_sat,
    input  logic [FRAC_BITS:0]                s1_light,
    input  logic [FRAC_BITS:0]                s1_hx,
    input  logic [hslrgb_pkg::SECTOR_W-1:0]   s1_sector,
    output logic                              s3_valid,
    output logic [FRAC_BITS:0]                s3_chroma,
    output logic [FRAC_BITS:0]                s3_x,
    output logic [FRAC_BITS:0]                s3_offset,
    output logic [hslrgb_pkg::SECTOR_W-1:0]   s3_sector
);
    import hslrgb_pkg::*;

    localparam int W = FRAC_BITS + 1;

    logic [2*W-1:0]      c_prod;
    logic [2*W-1:0]      x_prod;

    logic                v2_reg;
    logic [W-1:0]        c2_reg, light2_reg, hx2_reg;
    logic [SECTOR_W-1:0] sector2_reg;

    logic                v3_reg;
    logic [W-1:0]        c3_reg, x3_reg, m3_reg;
    logic [SECTOR_W-1:0] sector3_reg;

    assign c_prod = s1_span * s1_sat;
    assign x_prod = c2_reg * hx2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= s1_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // chroma never exceeds one, so W bits above the fraction hold it
        c2_reg      <= c_prod[FRAC_BITS+W-1:FRAC_BITS];
        light2_reg  <= s1_light;
        hx2_reg     <= s1_hx;
        sector2_reg <= s1_sector;

        c3_reg      <= c2_reg;
        x3_reg      <= x_prod[FRAC_BITS+W-1:FRAC_BITS];
        m3_reg      <= light2_reg - {1'b0, c2_reg[W-1:1]};
        sector3_reg <= sector2_reg;
    end

    assign s3_valid  = v3_reg;
    assign s3_chroma = c3_reg;
    assign s3_x      = x3_reg;
    assign s3_offset = m3_reg;
    assign s3_sector = sector3_reg;

endmodule

### design/hslrgb_mix.sv
// Last pipeline stage: adds the offset and places channels by hue sector.
// Depends on hslrgb_pkg.
module hslrgb_mix #(
    parameter int FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s3_valid,
    input  logic [FRAC_BITS:0]                s3_chroma,
    input  logic [FRAC_BITS:0]                s3_x,
    input  logic [FRAC_BITS:0]                s3_offset,
    input  logic [hslrgb_pkg::SECTOR_W-1:0]   s3_sector,
    output logic                              done,
    output logic [FRAC_BITS:0]                red,
    output logic [FRAC_BITS:0]                green,
    output logic [FRAC_BITS:0]                blue
);
    import hslrgb_pkg::*;

    localparam int W = FRAC_BITS + 1;

    logic [W-1:0] cm, xm, m;
    logic [W-1:0] r_next, g_next, b_next;
    logic         done_reg;
    logic [W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        cm = s3_chroma + s3_offset;
        xm = s3_x + s3_offset;
        m  = s3_offset;
        unique case (s3_sector)
            SEC_RED_YEL: begin r_next = cm; g_next = xm; b_next = m;  end
            SEC_YEL_GRN: begin r_next = xm; g_next = cm; b_next = m;  end
            SEC_GRN_CYN: begin r_next = m;  g_next = cm; b_next = xm; end
            SEC_CYN_BLU: begin r_next = m;  g_next = xm; b_next = cm; end
            SEC_BLU_MAG: begin r_next = xm; g_next = m;  b_next = cm; end
            SEC_MAG_RED: begin r_next = cm; g_next = m;  b_next = xm; end
            default:     begin r_next = m;  g_next = m;  b_next = m;  end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= r_next;
        green_reg <= g_next;
        blue_reg  <= b_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

### design/hsl_to_rgb_convert.sv
// HSL to RGB pixel converter, unsigned fixed point with FRAC_BITS fraction bits.
// A start passes the front, the two multiplier and the mix stages in turn before the done strobe.
// Throughput: one item per clock; busy is never raised, the four stages always advance.
// The receiver cannot stall; each result shows for one cycle with done high.
// Reset clears only the stage valid bits; data registers are left as they are.
// Depends on hslrgb_pkg, hslrgb_front, hslrgb_mul and hslrgb_mix.
module hsl_to_rgb_convert #(
    parameter int FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FRAC_BITS:0]   hue,
    input  logic [FRAC_BITS:0]   saturation,
    input  logic [FRAC_BITS:0]   lightness,
    output logic                 done,
    output logic [FRAC_BITS:0]   red,
    output logic [FRAC_BITS:0]   green,
    output logic [FRAC_BITS:0]   blue
);
    import hslrgb_pkg::*;

    localparam int W = FRAC_BITS + 1;

    logic                s1_valid;
    logic [W-1:0]        s1_span, s1_sat, s1_light, s1_hx;
    logic [SECTOR_W-1:0] s1_sector;

    logic                s3_valid;
    logic [W-1:0]        s3_chroma, s3_x, s3_offset;
    logic [SECTOR_W-1:0] s3_sector;

    assign busy = 1'b0;

    hslrgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start & ~busy),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .s1_valid   (s1_valid),
        .s1_span    (s1_span),
        .s1_sat     (s1_sat),
        .s1_light   (s1_light),
        .s1_hx      (s1_hx),
        .s1_sector  (s1_sector)
    );

    hslrgb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_span   (s1_span),
        .s1_sat    (s1_sat),
        .s1_light  (s1_light),
        .s1_hx     (s1_hx),
        .s1_sector (s1_sector),
        .s3_valid  (s3_valid),
        .s3_chroma (s3_chroma),
        .s3_x      (s3_x),
        .s3_offset (s3_offset),
        .s3_sector (s3_sector)
    );

    hslrgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .s3_valid  (s3_valid),
        .s3_chroma (s3_chroma),
        .s3_x      (s3_x),
        .s3_offset (s3_offset),
        .s3_sector (s3_sector),
        .done      (done),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule
